[rtl/h2r_pkg.sv]
`default_nettype none

package h2r_pkg;

    // field widths
    localparam int HUE_W   = 11;
    localparam int LEVEL_W = 8;
    localparam int NUM_W   = 16;
    localparam int PROD_W  = LEVEL_W + NUM_W;
    localparam int REM_W   = 18;
    localparam int CHANNELS = 3;

    // channel lanes
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // full-scale level and the scale denominator 255*255
    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'hFF;
    localparam logic [NUM_W-1:0]   SCALE_DEN  = 16'hFE01;

    // P = q*65536 + low; low + q*(65536-65025) is the remainder for q = P>>16
    localparam logic [8:0]       DEN_GAP     = 9'd511;
    localparam logic [REM_W-1:0] REM_ONE_DEN = REM_W'(SCALE_DEN);
    localparam logic [REM_W-1:0] REM_TWO_DEN = REM_W'(2 * 65025);

    // hue sectors, six per turn
    typedef enum logic [2:0] {
        SEC_RED_YELLOW   = 3'd0,
        SEC_YELLOW_GREEN = 3'd1,
        SEC_GREEN_CYAN   = 3'd2,
        SEC_CYAN_BLUE    = 3'd3,
        SEC_BLUE_MAGENTA = 3'd4,
        SEC_MAGENTA_RED  = 3'd5
    } t_sector;

    localparam logic [2:0] SECTOR_COUNT = 3'd6;

    typedef logic [CHANNELS-1:0][LEVEL_W-1:0] t_levels;
    typedef logic [CHANNELS-1:0][NUM_W-1:0]   t_nums;
    typedef logic [CHANNELS-1:0][PROD_W-1:0]  t_prods;

endpackage

`default_nettype wire

[rtl/h2r_if.sv]
`default_nettype none

// HSV item channel
interface h2r_hsv_if;
    logic                          valid;
    logic                          ready;
    logic [h2r_pkg::HUE_W-1:0]     hue;
    logic [h2r_pkg::LEVEL_W-1:0]   saturation;
    logic [h2r_pkg::LEVEL_W-1:0]   brightness;

    modport source (output valid, hue, saturation, brightness, input ready);
    modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

// RGB item channel
interface h2r_rgb_if;
    logic                          valid;
    logic                          ready;
    logic [h2r_pkg::LEVEL_W-1:0]   red;
    logic [h2r_pkg::LEVEL_W-1:0]   green;
    logic [h2r_pkg::LEVEL_W-1:0]   blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

`default_nettype wire

[rtl/hsv_to_rgb_converter.sv]
// HSV to 8-bit RGB, four register stages: decode, saturation term, brightness product,
// quotient by 65025 into the output register.
// An accepted item is registered in each stage in turn and is offered at the output once it
// reaches the output register.
// Throughput: one item per cycle; the whole pipe advances whenever the output register
// is empty or being taken, so a stall holds every stage in place.
// Reset (synchronous, active low) clears the stage valid bits only; no other state.
`default_nettype none

module hsv_to_rgb_converter (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    h2r_hsv_if.sink        i_hsv,
    h2r_rgb_if.source      o_rgb
);

    logic advance;

    // stage valid bits
    logic r_v1, r_v2, r_v3, r_v4;

    // stage payloads
    logic [h2r_pkg::LEVEL_W-1:0] r_sat1;
    logic [h2r_pkg::LEVEL_W-1:0] r_val1, r_val2;
    h2r_pkg::t_levels            r_gap1;     // 255 - level per channel
    h2r_pkg::t_nums              r_num2;
    h2r_pkg::t_prods             r_prod3;
    h2r_pkg::t_levels            r_rgb4;

    logic [2:0]                  sector_raw;
    h2r_pkg::t_sector            sector;
    logic [h2r_pkg::LEVEL_W-1:0] ramp;
    h2r_pkg::t_levels            level;
    h2r_pkg::t_levels            n_gap1;
    h2r_pkg::t_nums              n_num2;
    h2r_pkg::t_prods             n_prod3;
    h2r_pkg::t_levels            n_rgb4;

    assign advance     = !r_v4 || o_rgb.ready;
    assign i_hsv.ready = advance;

    // sector wrap, ramp mirror and saturated primary
    always_comb begin
        sector_raw = i_hsv.hue[h2r_pkg::HUE_W-1:h2r_pkg::LEVEL_W];
        if (sector_raw >= h2r_pkg::SECTOR_COUNT) begin
            sector_raw = sector_raw - h2r_pkg::SECTOR_COUNT;
        end
        sector = h2r_pkg::t_sector'(sector_raw);
        ramp   = sector_raw[0] ? ~i_hsv.hue[h2r_pkg::LEVEL_W-1:0]
                               :  i_hsv.hue[h2r_pkg::LEVEL_W-1:0];
        level  = '0;
        unique case (sector)
            h2r_pkg::SEC_RED_YELLOW: begin
                level[h2r_pkg::CH_RED]   = h2r_pkg::FULL_LEVEL;
                level[h2r_pkg::CH_GREEN] = ramp;
            end
            h2r_pkg::SEC_YELLOW_GREEN: begin
                level[h2r_pkg::CH_RED]   = ramp;
                level[h2r_pkg::CH_GREEN] = h2r_pkg::FULL_LEVEL;
            end
            h2r_pkg::SEC_GREEN_CYAN: begin
                level[h2r_pkg::CH_GREEN] = h2r_pkg::FULL_LEVEL;
                level[h2r_pkg::CH_BLUE]  = ramp;
            end
            h2r_pkg::SEC_CYAN_BLUE: begin
                level[h2r_pkg::CH_GREEN] = ramp;
                level[h2r_pkg::CH_BLUE]  = h2r_pkg::FULL_LEVEL;
            end
            h2r_pkg::SEC_BLUE_MAGENTA: begin
                level[h2r_pkg::CH_RED]   = ramp;
                level[h2r_pkg::CH_BLUE]  = h2r_pkg::FULL_LEVEL;
            end
            h2r_pkg::SEC_MAGENTA_RED: begin
                level[h2r_pkg::CH_RED]   = h2r_pkg::FULL_LEVEL;
                level[h2r_pkg::CH_BLUE]  = ramp;
            end
            default: begin
                level = '0;
            end
        endcase
        for (int ch = 0; ch < h2r_pkg::CHANNELS; ch++) begin
            n_gap1[ch] = h2r_pkg::FULL_LEVEL - level[ch];
        end
    end

    // numerator 65025 - s*(255-c), never negative
    always_comb begin
        for (int ch = 0; ch < h2r_pkg::CHANNELS; ch++) begin
            n_num2[ch] = h2r_pkg::SCALE_DEN
                       - (h2r_pkg::NUM_W'(r_sat1) * h2r_pkg::NUM_W'(r_gap1[ch]));
        end
    end

    // brightness times numerator, below 2^24
    always_comb begin
        for (int ch = 0; ch < h2r_pkg::CHANNELS; ch++) begin
            n_prod3[ch] = h2r_pkg::PROD_W'(r_val2) * h2r_pkg::PROD_W'(r_num2[ch]);
        end
    end

    // divide by 65025: estimate with >>16, true quotient is at most two above
    always_comb begin
        logic [h2r_pkg::LEVEL_W-1:0] q_est;
        logic [h2r_pkg::REM_W-1:0]   rem;
        for (int ch = 0; ch < h2r_pkg::CHANNELS; ch++) begin
            q_est = r_prod3[ch][h2r_pkg::PROD_W-1:h2r_pkg::NUM_W];
            rem   = h2r_pkg::REM_W'(r_prod3[ch][h2r_pkg::NUM_W-1:0])
                  + (h2r_pkg::REM_W'(q_est) * h2r_pkg::REM_W'(h2r_pkg::DEN_GAP));
            if (rem >= h2r_pkg::REM_TWO_DEN) begin
                n_rgb4[ch] = q_est + 8'd2;
            end else if (rem >= h2r_pkg::REM_ONE_DEN) begin
                n_rgb4[ch] = q_est + 8'd1;
            end else begin
                n_rgb4[ch] = q_est;
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (advance) begin
            r_v1 <= i_hsv.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_sat1  <= i_hsv.saturation;
            r_val1  <= i_hsv.brightness;
            r_gap1  <= n_gap1;
            r_val2  <= r_val1;
            r_num2  <= n_num2;
            r_prod3 <= n_prod3;
            r_rgb4  <= n_rgb4;
        end
    end

    assign o_rgb.valid = r_v4;
    assign o_rgb.red   = r_rgb4[h2r_pkg::CH_RED];
    assign o_rgb.green = r_rgb4[h2r_pkg::CH_GREEN];
    assign o_rgb.blue  = r_rgb4[h2r_pkg::CH_BLUE];

endmodule

`default_nettype wire

[rtl/h2r_checker.sv]
`default_nettype none

module h2r_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_ready,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [h2r_pkg::LEVEL_W-1:0]   i_red,
    input wire logic [h2r_pkg::LEVEL_W-1:0]   i_green,
    input wire logic [h2r_pkg::LEVEL_W-1:0]   i_blue
);

    // pipe moves exactly when the output register can drain
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready == (!i_out_valid || i_out_ready))
        else $error("input ready does not follow output drain");

    // an accepted item that meets no stall is offered at the output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) ##1 i_in_ready ##1 i_in_ready ##1 i_in_ready
        |=> i_out_valid)
        else $error("item lost in pipeline");

    // stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output valid dropped under stall");

    // stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> ($stable(i_red) && $stable(i_green) && $stable(i_blue)))
        else $error("output payload changed under stall");

endmodule

bind hsv_to_rgb_converter h2r_checker u_h2r_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_hsv.valid),
    .i_in_ready  (i_hsv.ready),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready),
    .i_red       (o_rgb.red),
    .i_green     (o_rgb.green),
    .i_blue      (o_rgb.blue)
);

`default_nettype wire

[bench/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // one HSV item as queued for the driver
    typedef struct {
        logic [h2r_pkg::HUE_W-1:0]   hue;
        logic [h2r_pkg::LEVEL_W-1:0] sat;
        logic [h2r_pkg::LEVEL_W-1:0] bright;
        bit                          drain_first;  // hold this item back until the pipe is empty
    } t_hsv_item;

    // receiver ready patterns
    typedef enum logic [1:0] {
        RX_STEADY,
        RX_COIN,
        RX_THREE_OF_FOUR,
        RX_MOSTLY
    } t_rx_mode;

    localparam int RANDOM_ITEMS = 1750;
    localparam int LONG_HOLD    = 120;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // driven inputs, known from time zero
    logic                        drv_valid  = 1'b0;
    logic [h2r_pkg::HUE_W-1:0]   drv_hue    = '0;
    logic [h2r_pkg::LEVEL_W-1:0] drv_sat    = '0;
    logic [h2r_pkg::LEVEL_W-1:0] drv_bright = '0;
    logic                        rx_ready   = 1'b0;

    t_hsv_item         pending_hsv_q[$];
    h2r_pkg::t_levels  expected_rgb_q[$];
    int                fail_count = 0;
    string             lane_name[h2r_pkg::CHANNELS] = '{"red", "green", "blue"};

    h2r_hsv_if hsv_ch();
    h2r_rgb_if rgb_ch();

    assign hsv_ch.valid      = drv_valid;
    assign hsv_ch.hue        = drv_hue;
    assign hsv_ch.saturation = drv_sat;
    assign hsv_ch.brightness = drv_bright;
    assign rgb_ch.ready      = rx_ready;

    hsv_to_rgb_converter u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hsv   (hsv_ch),
        .o_rgb   (rgb_ch)
    );

    // clock and reset
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // expected RGB levels for one HSV item
    function automatic h2r_pkg::t_levels hsv_to_levels(t_hsv_item it);
        logic [2:0]                  sec_raw;
        h2r_pkg::t_sector            sec;
        logic [h2r_pkg::LEVEL_W-1:0] ramp;
        h2r_pkg::t_levels            primary;
        h2r_pkg::t_levels            scaled;
        int unsigned                 den;
        int unsigned                 num;
        int unsigned                 quot;
        int                          ch;
        den     = 32'(h2r_pkg::SCALE_DEN);
        sec_raw = it.hue[h2r_pkg::HUE_W-1:8];
        // sectors 6 and 7 wrap onto 0 and 1
        if (sec_raw >= h2r_pkg::SECTOR_COUNT) begin
            sec_raw = sec_raw - h2r_pkg::SECTOR_COUNT;
        end
        sec  = h2r_pkg::t_sector'(sec_raw);
        ramp = sec_raw[0] ? h2r_pkg::FULL_LEVEL - it.hue[7:0] : it.hue[7:0];
        primary = '0;
        case (sec)
            h2r_pkg::SEC_RED_YELLOW: begin
                primary[h2r_pkg::CH_RED]   = h2r_pkg::FULL_LEVEL;
                primary[h2r_pkg::CH_GREEN] = ramp;
            end
            h2r_pkg::SEC_YELLOW_GREEN: begin
                primary[h2r_pkg::CH_RED]   = ramp;
                primary[h2r_pkg::CH_GREEN] = h2r_pkg::FULL_LEVEL;
            end
            h2r_pkg::SEC_GREEN_CYAN: begin
                primary[h2r_pkg::CH_GREEN] = h2r_pkg::FULL_LEVEL;
                primary[h2r_pkg::CH_BLUE]  = ramp;
            end
            h2r_pkg::SEC_CYAN_BLUE: begin
                primary[h2r_pkg::CH_GREEN] = ramp;
                primary[h2r_pkg::CH_BLUE]  = h2r_pkg::FULL_LEVEL;
            end
            h2r_pkg::SEC_BLUE_MAGENTA: begin
                primary[h2r_pkg::CH_RED]   = ramp;
                primary[h2r_pkg::CH_BLUE]  = h2r_pkg::FULL_LEVEL;
            end
            default: begin
                primary[h2r_pkg::CH_RED]   = h2r_pkg::FULL_LEVEL;
                primary[h2r_pkg::CH_BLUE]  = ramp;
            end
        endcase
        // v * (65025 - s*(255-c)) / 65025, truncating
        for (ch = 0; ch < h2r_pkg::CHANNELS; ch++) begin
            num  = den - int'(it.sat) * (int'(h2r_pkg::FULL_LEVEL) - int'(primary[ch]));
            quot = (int'(it.bright) * num) / den;
            scaled[ch] = quot[h2r_pkg::LEVEL_W-1:0];
        end
        return scaled;
    endfunction

    task automatic queue_hsv(int hue, int sat, int bright, bit drain_first);
        t_hsv_item it;
        it.hue         = hue[h2r_pkg::HUE_W-1:0];
        it.sat         = sat[h2r_pkg::LEVEL_W-1:0];
        it.bright      = bright[h2r_pkg::LEVEL_W-1:0];
        it.drain_first = drain_first;
        pending_hsv_q.push_back(it);
    endtask

    // driver: bursts of random length, random gaps between them
    t_hsv_item cur_item;
    t_hsv_item next_item;
    int        burst_left = 8;
    int        gap_left   = 0;
    bit        holding;
    bit        offer;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else begin
            holding = drv_valid;
            if (drv_valid && hsv_ch.ready) begin
                expected_rgb_q.push_back(hsv_to_levels(cur_item));
                holding = 1'b0;
            end
            // an offered item stays put until taken
            if (!holding) begin
                offer = 1'b0;
                if (gap_left != 0) begin
                    gap_left--;
                end else if (pending_hsv_q.size() != 0) begin
                    next_item = pending_hsv_q[0];
                    if (!next_item.drain_first || expected_rgb_q.size() == 0) begin
                        cur_item = pending_hsv_q.pop_front();
                        offer    = 1'b1;
                        burst_left--;
                        if (burst_left <= 0) begin
                            burst_left = $urandom_range(1, 24);
                            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                        end
                    end
                end
                drv_valid <= offer;
                if (offer) begin
                    drv_hue    <= cur_item.hue;
                    drv_sat    <= cur_item.sat;
                    drv_bright <= cur_item.bright;
                end
            end
        end
    end

    // receiver: changing ready pattern plus a few long hold-offs
    int       rx_cycle  = 0;
    int       hold_left = 0;
    t_rx_mode rx_mode   = RX_STEADY;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_ready <= 1'b0;
        end else begin
            rx_cycle++;
            if (rx_cycle == 600 || rx_cycle == 1500 || rx_cycle == 2500) begin
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                rx_ready <= 1'b0;
            end else begin
                if (rx_cycle % 64 == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(0, 3));
                end
                case (rx_mode)
                    RX_STEADY:        rx_ready <= 1'b1;
                    RX_COIN:          rx_ready <= 1'($urandom_range(0, 1));
                    RX_THREE_OF_FOUR: rx_ready <= (rx_cycle % 4 != 0);
                    default:          rx_ready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // monitor: compare each RGB item with the oldest expectation
    h2r_pkg::t_levels want_rgb;
    h2r_pkg::t_levels got_rgb;

    always @(posedge i_clk) begin
        if (i_rst_n && rgb_ch.valid && rx_ready) begin
            got_rgb[h2r_pkg::CH_RED]   = rgb_ch.red;
            got_rgb[h2r_pkg::CH_GREEN] = rgb_ch.green;
            got_rgb[h2r_pkg::CH_BLUE]  = rgb_ch.blue;
            if (expected_rgb_q.size() == 0) begin
                $display("%0t: unexpected RGB item, expected none, actual r=%0d g=%0d b=%0d",
                         $realtime, got_rgb[h2r_pkg::CH_RED], got_rgb[h2r_pkg::CH_GREEN],
                         got_rgb[h2r_pkg::CH_BLUE]);
                fail_count++;
            end else begin
                want_rgb = expected_rgb_q.pop_front();
                for (int ch = 0; ch < h2r_pkg::CHANNELS; ch++) begin
                    if (got_rgb[ch] !== want_rgb[ch]) begin
                        $display("%0t: %s mismatch, expected %0d, actual %0d",
                                 $realtime, lane_name[ch], want_rgb[ch], got_rgb[ch]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // stimulus and end of run
    initial begin
        int hue;
        int sat;
        int bright;

        // sector edges, wrapped hues, grey, black and a few odd mixes
        queue_hsv(0,    255, 255, 1'b0);
        queue_hsv(255,  255, 255, 1'b0);
        queue_hsv(256,  255, 255, 1'b0);
        queue_hsv(511,  255, 255, 1'b0);
        queue_hsv(512,  255, 255, 1'b0);
        queue_hsv(767,  255, 255, 1'b0);
        queue_hsv(768,  255, 255, 1'b0);
        queue_hsv(1023, 255, 255, 1'b0);
        queue_hsv(1024, 255, 255, 1'b0);
        queue_hsv(1279, 255, 255, 1'b0);
        queue_hsv(1280, 255, 255, 1'b0);
        queue_hsv(1535, 255, 255, 1'b0);
        queue_hsv(1536, 255, 255, 1'b0);
        queue_hsv(1791, 255, 255, 1'b0);
        queue_hsv(1792, 200, 255, 1'b0);
        queue_hsv(2047, 255, 255, 1'b0);
        queue_hsv(700,  0,   200, 1'b0);
        queue_hsv(1200, 255, 0,   1'b0);
        queue_hsv(0,    0,   0,   1'b0);
        queue_hsv(2047, 0,   255, 1'b0);
        queue_hsv(128,  128, 128, 1'b0);
        queue_hsv(1000, 1,   254, 1'b0);
        queue_hsv(300,  254, 1,   1'b0);

        // random part, some hues above the nominal range
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            hue = ($urandom_range(0, 9) == 0) ? $urandom_range(1536, 2047)
                                               : $urandom_range(0, 1535);
            case ($urandom_range(0, 7))
                0:       sat = 0;
                1:       sat = 255;
                default: sat = $urandom_range(0, 255);
            endcase
            case ($urandom_range(0, 7))
                0:       bright = 0;
                1:       bright = 255;
                default: bright = $urandom_range(0, 255);
            endcase
            queue_hsv(hue, sat, bright, (i == 600 || i == 1200));
        end

        @(posedge i_clk);
        while (!i_rst_n || pending_hsv_q.size() != 0 || drv_valid
               || expected_rgb_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (16) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
